>>> rtl/msp_pkg.sv
package msp_pkg;

	localparam int TOTAL_W = 11;

	localparam logic [7:0] SX_START   = 8'hF0;
	localparam logic [7:0] SX_STOP    = 8'hF7;
	localparam logic [7:0] STATUS_MIN = 8'h80;
	localparam logic [7:0] PROG_MIN   = 8'hC0;
	localparam logic [7:0] PITCH_MIN  = 8'hE0;

	localparam logic KIND_SHORT = 1'b0;
	localparam logic KIND_SYSEX = 1'b1;

	// message length of the system status bytes 0xF0..0xFF, by low nibble
	localparam logic [1:0] SYS_LEN [16] = '{
		2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd0,
		2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0
	};

	typedef struct packed {
		logic               kind;
		logic [7:0]         first_byte;
		logic [7:0]         data_one;
		logic [7:0]         data_two;
		logic [1:0]         message_length;
		logic               sysex_end;
		logic [TOTAL_W-1:0] sysex_total;
	} result_t;

	// results of one item, in delivery order; count is 0, 1 or 2
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} result_pair_t;

	function automatic logic [1:0] length_of(input logic [7:0] s);
		logic [1:0] len;
		begin
			if (s < STATUS_MIN)
				len = 2'd0;
			else if (s < PROG_MIN)
				len = 2'd3;
			else if (s < PITCH_MIN)
				len = 2'd2;
			else if (s < SX_START)
				len = 2'd3;
			else
				len = SYS_LEN[s[3:0]];
			return len;
		end
	endfunction

endpackage

>>> rtl/midi_stream_parser_unit.sv
// MIDI stream parser. Takes one raw MIDI byte per item on the slave side and
// frames it into messages on the master side. A status byte (bit 7 set) sets
// the running status and the message length (3 for note/controller/pitch
// bend, 2 for program change and channel pressure, per-code length for
// system messages). Each complete short message is one result item; data
// bytes after it reuse the running status, so a one-byte system message is
// repeated on each following data byte. System exclusive is passed through
// byte by byte: 0xF0 first, then data bytes until SYSEX_CAPACITY-1 bytes are
// kept (later ones are dropped), and any status byte closes it with a 0xF7
// item carrying tlast and the total length before being handled itself.
// Rate: one byte accepted per clock while the result queue has room. A byte gives
// zero, one or two result items; a byte that closes a sysex and also opens a new
// sysex or completes a one-byte message gives two, sent one after the other. A
// byte passes through the input register, then the two-entry result queue. The
// input register stalls only while the result queue lacks room for the byte's results.
module midi_stream_parser_unit #(
	parameter int SYSEX_CAPACITY = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] midi_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] first_byte, [15:8] data_one,
	                               // [23:16] data_two, [25:24] message_length,
	                               // [36:26] sysex_total, [39:37] zero
	output logic        m_tlast,   // sysex_end
	output logic        m_tuser    // result_kind
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  fire;
	logic [1:0]            free_slots;
	msp_pkg::result_pair_t pair;

	// the byte in the input register is processed once the queue can take
	// all of its results
	assign fire     = valid_s1 && (pair.count <= free_slots);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	msp_frame #(
		.SYSEX_CAPACITY(SYSEX_CAPACITY)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.midi_byte(byte_s1),
		.fire     (fire),
		.pair     (pair)
	);

	msp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pair),
		.fire      (fire),
		.free_slots(free_slots),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

>>> rtl/msp_frame.sv
// Running-status framer: state registers plus the single-pass update for one byte.
module msp_frame #(
	parameter int SYSEX_CAPACITY = 1024,
	localparam int CNT_W = $clog2(SYSEX_CAPACITY + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           midi_byte,
	input  logic                 fire,
	output msp_pkg::result_pair_t pair
);

	logic [7:0]       rs_q, rs_d;
	logic [1:0]       len_q, len_d;
	logic [1:0]       pos_q, pos_d;
	logic [1:0]       pos_c;
	logic [7:0]       mb_q [3];
	logic [7:0]       mb_d [3];
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             is_st;
	msp_pkg::result_t sx_res, msg_res;

	assign is_st = midi_byte[7];

	always_comb begin
		rs_d  = rs_q;
		len_d = len_q;
		pos_d = pos_q;
		pos_c = 2'd0;
		mb_d  = mb_q;
		cnt_d = cnt_q;
		pair  = '0;
		sx_res  = '0;
		msg_res = '0;
		if (rs_q == msp_pkg::SX_START && !is_st) begin
			// sysex data: pass through until the buffer limit, then drop
			if (cnt_q < CNT_W'(SYSEX_CAPACITY - 1)) begin
				pair.r0.kind       = msp_pkg::KIND_SYSEX;
				pair.r0.first_byte = midi_byte;
				pair.count         = 2'd1;
				cnt_d              = cnt_q + 1'b1;
			end
		end else begin
			if (rs_q == msp_pkg::SX_START) begin
				// any status closes the sysex
				cnt_d                = cnt_q + 1'b1;
				pair.r0.kind         = msp_pkg::KIND_SYSEX;
				pair.r0.first_byte   = msp_pkg::SX_STOP;
				pair.r0.sysex_end    = 1'b1;
				pair.r0.sysex_total  = msp_pkg::TOTAL_W'(cnt_d);
				pair.count           = 2'd1;
			end
			if (is_st) begin
				rs_d  = midi_byte;
				pos_d = 2'd0;
				len_d = msp_pkg::length_of(midi_byte);
				if (midi_byte == msp_pkg::SX_START) begin
					sx_res.kind       = msp_pkg::KIND_SYSEX;
					sx_res.first_byte = msp_pkg::SX_START;
					if (pair.count == 2'd0)
						pair.r0 = sx_res;
					else
						pair.r1 = sx_res;
					pair.count = pair.count + 2'd1;
					cnt_d      = CNT_W'(1);
				end
			end
			if (len_d != 2'd0) begin
				pos_c        = (pos_d > 2'd2) ? 2'd2 : pos_d;
				mb_d[pos_c]  = midi_byte;
				pos_d        = pos_c + 2'd1;
				if (pos_d >= len_d) begin
					msg_res.kind           = msp_pkg::KIND_SHORT;
					msg_res.first_byte     = mb_d[0];
					msg_res.data_one       = (len_d >= 2'd2) ? mb_d[1] : 8'd0;
					msg_res.data_two       = (len_d >= 2'd3) ? mb_d[2] : 8'd0;
					msg_res.message_length = len_d;
					if (pair.count == 2'd0)
						pair.r0 = msg_res;
					else
						pair.r1 = msg_res;
					pair.count = pair.count + 2'd1;
					// running status: status byte stays, next data starts at slot 1
					pos_d = 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q  <= '0;
			len_q <= '0;
			pos_q <= '0;
			mb_q  <= '{default: '0};
			cnt_q <= '0;
		end else if (fire) begin
			rs_q  <= rs_d;
			len_q <= len_d;
			pos_q <= pos_d;
			mb_q  <= mb_d;
			cnt_q <= cnt_d;
		end
	end

	a_two_starts_with_end: assert property (@(posedge clk) disable iff (!arst_n)
		pair.count == 2'd2 |-> pair.r0.sysex_end)
		else $error("second result without a sysex close ahead of it");

	a_sysex_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		rs_q == msp_pkg::SX_START |-> len_q == 2'd0)
		else $error("sysex running status with a message length");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(SYSEX_CAPACITY))
		else $error("sysex count beyond capacity");

endmodule

>>> rtl/msp_outq.sv
// Two-entry result queue; slot 0 drives the master side.
module msp_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  msp_pkg::result_pair_t push,
	input  logic                  fire,
	output logic [1:0]            free_slots,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [39:0]           m_tdata,
	output logic                  m_tlast,
	output logic                  m_tuser
);

	logic [1:0]       occ_q, occ_a, occ_d, push_n;
	logic             pop;
	msp_pkg::result_t slot0_q, slot1_q, slot0_d, slot1_d, s0a;

	assign m_tvalid   = (occ_q != 2'd0);
	assign pop        = m_tvalid && m_tready;
	assign occ_a      = occ_q - {1'b0, pop};
	assign s0a        = pop ? slot1_q : slot0_q;
	assign free_slots = 2'd2 - occ_a;
	assign push_n     = fire ? push.count : 2'd0;
	assign occ_d      = occ_a + push_n;

	always_comb begin
		slot0_d = s0a;
		slot1_d = slot1_q;
		case (occ_a)
			2'd0: begin
				slot0_d = push.r0;
				slot1_d = push.r1;
			end
			2'd1: begin
				slot1_d = push.r0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			occ_q <= '0;
		else
			occ_q <= occ_d;
	end

	always_ff @(posedge clk) begin
		slot0_q <= slot0_d;
		slot1_q <= slot1_d;
	end

	assign m_tdata = {3'b000, slot0_q.sysex_total, slot0_q.message_length,
		slot0_q.data_two, slot0_q.data_one, slot0_q.first_byte};
	assign m_tlast = slot0_q.sysex_end;
	assign m_tuser = slot0_q.kind;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 2'd2)
		else $error("result queue over capacity");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (occ_a + push.count) <= 2'd2)
		else $error("results pushed without room");

	a_hold_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result item changed while waiting");

endmodule
